// ===== rtl/core/fsha_pkg.sv =====
// Shared types, constants and helper functions of the free space hole analyzer.
package fsha_pkg;

    // Directory depth and derived widths
    localparam int MAX_SLOTS = 64;
    localparam int ADDR_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int TALLY_W   = 7;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // Entry state codes
    localparam logic [STATE_W-1:0] ST_FREE    = 2'd0;
    localparam logic [STATE_W-1:0] ST_WRITING = 2'd1;
    localparam logic [STATE_W-1:0] ST_VALID   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END = 2'd1;

    // One occupied range in the store
    typedef struct packed {
        logic [DATA_W-1:0] rng_off;
        logic [DATA_W-1:0] rng_end;
    } t_range;

    localparam int RANGE_W = $bits(t_range);

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // take the request on the input ports
        logic ins_shift;   // move entry j-1 up to j, step j down
        logic ins_put;     // write new range at j, grow the store
        logic scan_init;   // load cursor and clear scan accumulators
        logic scan_rd;     // read range at scan index, step index
        logic tail;        // evaluate the gap up to region_end
        logic load_out;    // capture the result registers
        logic clear_pass;  // zero counters, sums and store fill
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_ins;     // incoming request needs a store insertion
        logic count_zero;   // store is empty
        logic rd_gt;        // stored offset above the new offset
        logic idx_is1;      // insertion index equals one
        logic idx_lt_count; // scan index still inside the store
    } t_sts;

    // Add with saturation at all ones
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    endfunction

    // Increment with saturation at all ones
    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] a);
        return (a == TALLY_MAX) ? a : a + TALLY_W'(1);
    endfunction

endpackage

// ===== rtl/core/fsha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fsha_dpath.sv =====
// Datapath: pass counters, sorted range store, gap scan pipeline and result registers.
module fsha_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fsha_pkg::t_cmd                    i_cmd,
    output fsha_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_valid,
    input  logic [fsha_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsha_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic [fsha_pkg::STATE_W-1:0]      i_entry_state,
    input  logic [fsha_pkg::DATA_W-1:0]       i_entry_offset,
    input  logic [fsha_pkg::DATA_W-1:0]       i_entry_capacity,
    input  logic [fsha_pkg::DATA_W-1:0]       i_entry_size,
    output logic [fsha_pkg::TALLY_W-1:0]      o_slots_used,
    output logic [fsha_pkg::TALLY_W-1:0]      o_files,
    output logic [fsha_pkg::DATA_W-1:0]       o_used_bytes,
    output logic [fsha_pkg::DATA_W-1:0]       o_reserved_bytes,
    output logic [fsha_pkg::DATA_W-1:0]       o_free_bytes,
    output logic [fsha_pkg::DATA_W-1:0]       o_largest_hole,
    output logic [fsha_pkg::DATA_W-1:0]       o_region_bytes
);
    import fsha_pkg::*;

    // Configuration
    logic [DATA_W-1:0]  r_data_start;
    logic [DATA_W-1:0]  r_region_end;

    // Pass state
    logic [CNT_W-1:0]   r_count;
    logic [TALLY_W-1:0] r_slots;
    logic [TALLY_W-1:0] r_files;
    logic [DATA_W-1:0]  r_used;
    logic [DATA_W-1:0]  r_reserved;

    // Insertion and scan
    logic [CNT_W-1:0]   r_idx;
    t_range             r_new;
    logic               r_v1;
    logic               r_v2;
    logic [DATA_W-1:0]  r_cursor;
    logic [DATA_W-1:0]  r_gap;
    logic [DATA_W-1:0]  r_free;
    logic [DATA_W-1:0]  r_largest;

    // Result registers
    logic [TALLY_W-1:0] r_o_slots;
    logic [TALLY_W-1:0] r_o_files;
    logic [DATA_W-1:0]  r_o_used;
    logic [DATA_W-1:0]  r_o_reserved;
    logic [DATA_W-1:0]  r_o_free;
    logic [DATA_W-1:0]  r_o_largest;
    logic [DATA_W-1:0]  r_o_region;

    // Store ports
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_range             mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    t_range             mem_rdata;

    logic [CNT_W-1:0]   idx_m2;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   n_raddr;
    logic               is_range;
    logic               store_full;
    logic [DATA_W-1:0]  s1_src;
    logic [DATA_W-1:0]  s1_gap;

    assign is_range   = (i_entry_state == ST_WRITING) || (i_entry_state == ST_VALID);
    assign store_full = (r_count == CNT_W'(MAX_SLOTS));

    // Status to the controller
    assign o_sts.need_ins     = is_range && !store_full;
    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.rd_gt        = (mem_rdata.rng_off > r_new.rng_off);
    assign o_sts.idx_is1      = (r_idx == CNT_W'(1));
    assign o_sts.idx_lt_count = (r_idx < r_count);

    // Select the read address: scan index, shift source or top of store
    assign idx_m2 = r_idx - CNT_W'(2);
    assign cnt_m1 = r_count - CNT_W'(1);

    always_comb begin
        if (i_cmd.scan_rd) begin
            n_raddr = r_idx;
        end else if (i_cmd.ins_shift) begin
            n_raddr = idx_m2;
        end else begin
            n_raddr = cnt_m1;
        end
    end

    assign mem_raddr = n_raddr[ADDR_W-1:0];
    assign mem_we    = i_cmd.ins_shift || i_cmd.ins_put;
    assign mem_waddr = r_idx[ADDR_W-1:0];
    assign mem_wdata = i_cmd.ins_shift ? mem_rdata : r_new;

    fsha_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Scan stage one: gap from cursor to next range start or to region_end
    assign s1_src = i_cmd.tail ? r_region_end : mem_rdata.rng_off;
    assign s1_gap = (s1_src > r_cursor) ? (s1_src - r_cursor) : '0;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= '0;
            r_region_end <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DATA_START: r_data_start <= i_cfg_data;
                CFG_REGION_END: r_region_end <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Update pass counters and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_slots    <= '0;
            r_files    <= '0;
            r_used     <= '0;
            r_reserved <= '0;
        end else if (i_cmd.clear_pass) begin
            r_count    <= '0;
            r_slots    <= '0;
            r_files    <= '0;
            r_used     <= '0;
            r_reserved <= '0;
        end else begin
            if (i_cmd.accept && (i_entry_state != ST_FREE)) begin
                r_slots <= sat_inc(r_slots);
            end
            if (i_cmd.accept && (i_entry_state == ST_VALID)) begin
                r_files    <= sat_inc(r_files);
                r_used     <= sat_add(r_used, i_entry_size);
                r_reserved <= sat_add(r_reserved, i_entry_capacity);
            end
            if (i_cmd.ins_put) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Advance the insertion and scan index; latch the new range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.accept) begin
            r_idx <= r_count;
        end else if (i_cmd.ins_shift) begin
            r_idx <= r_idx - CNT_W'(1);
        end else if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new.rng_off <= i_entry_offset;
            r_new.rng_end <= i_entry_offset + i_entry_capacity;
        end
    end

    // Scan pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1 || i_cmd.tail;
        end
    end

    // Scan stage one: move cursor, register the gap
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_cursor <= r_data_start;
        end else if (r_v1 && (mem_rdata.rng_end > r_cursor)) begin
            r_cursor <= mem_rdata.rng_end;
        end
        r_gap <= s1_gap;
    end

    // Scan stage two: accumulate free bytes and track the largest hole
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_free    <= '0;
            r_largest <= '0;
        end else if (r_v2) begin
            r_free <= sat_add(r_free, r_gap);
            if (r_gap > r_largest) begin
                r_largest <= r_gap;
            end
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_slots    <= r_slots;
            r_o_files    <= r_files;
            r_o_used     <= r_used;
            r_o_reserved <= r_reserved;
            r_o_free     <= r_free;
            r_o_largest  <= r_largest;
            r_o_region   <= r_region_end - r_data_start;
        end
    end

    assign o_slots_used     = r_o_slots;
    assign o_files          = r_o_files;
    assign o_used_bytes     = r_o_used;
    assign o_reserved_bytes = r_o_reserved;
    assign o_free_bytes     = r_o_free;
    assign o_largest_hole   = r_o_largest;
    assign o_region_bytes   = r_o_region;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SLOTS))
        else $error("range store fill above depth");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_put && !i_cmd.clear_pass |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insertion did not grow the store by one");

    a_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_shift |-> (r_idx != '0) && (r_idx <= r_count))
        else $error("shift index outside the store");

    a_tail_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail |-> !r_v1 && !i_cmd.scan_rd)
        else $error("tail gap overlaps a range read");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_pass |=> (r_count == '0) && (r_slots == '0) && (r_files == '0))
        else $error("pass state not cleared");
`endif

endmodule

// ===== rtl/core/fsha_ctrl.sv =====
// Controller: sequences acceptance, sorted insertion, gap scan and result handoff.
module fsha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_entry,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  fsha_pkg::t_sts i_sts,
    output fsha_pkg::t_cmd o_cmd
);
    import fsha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_START,
        S_SCAN,
        S_TAIL,
        S_FLUSH,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;
    logic   n_last;
    logic   r_o_valid;
    logic   n_o_valid;
    logic   out_free;
    logic   out_take;

    assign out_take = r_o_valid && !i_stall;
    assign out_free = !r_o_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_last_entry;
                    if (i_sts.need_ins) begin
                        n_state = i_sts.count_zero ? S_INS_PUT : S_INS_CMP;
                    end else if (i_last_entry) begin
                        n_state = S_START;
                    end
                end
            end
            S_INS_CMP: begin
                if (i_sts.rd_gt) begin
                    o_cmd.ins_shift = 1'b1;
                    if (i_sts.idx_is1) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = r_last ? S_START : S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_cmd.ins_put = 1'b1;
                n_state       = r_last ? S_START : S_IDLE;
            end
            S_START: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.idx_lt_count) begin
                    o_cmd.scan_rd = 1'b1;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_FLUSH;
            end
            S_FLUSH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.clear_pass = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        n_o_valid = r_o_valid;
        if (o_cmd.load_out) begin
            n_o_valid = 1'b1;
        end else if (out_take) begin
            n_o_valid = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !r_o_valid || !i_stall)
        else $error("result loaded over a pending result");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) && r_o_valid && i_stall |=> r_state == S_RESULT)
        else $error("result state left while output blocked");

    a_scan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_init |-> r_last)
        else $error("scan started without a last request");
`endif

endmodule

// ===== rtl/core/free_space_hole_analyzer_top.sv =====
// Top level of the free space hole analyzer: controller, datapath and config port.
//
//  channel   valid        flow control   payload
//  -------   -----------  -------------  ------------------------------------------------
//  entry     i_valid      o_stall        i_entry_state/offset/capacity/size, i_last_entry
//  result    o_valid      i_stall        o_slots_used, o_files, o_*_bytes, o_largest_hole
//  config    i_cfg_valid  o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request with no range to store needs no insertion state; a stored range is
// written in S_INS_CMP or S_INS_PUT after the stored ranges above its offset (up to
// MAX_SLOTS - 1) are shifted up one at a time through the single-write range RAM. The last
// request then runs the gap scan, one RAM read per stored range. Reset clears the controller
// and pass counters; the range RAM needs no clearing. Requests are taken while a result still
// waits on o_valid; a finished pass holds in place until the result register is free.
module free_space_hole_analyzer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fsha_pkg::STATE_W-1:0]   i_entry_state,
    input  logic [fsha_pkg::DATA_W-1:0]    i_entry_offset,
    input  logic [fsha_pkg::DATA_W-1:0]    i_entry_capacity,
    input  logic [fsha_pkg::DATA_W-1:0]    i_entry_size,
    input  logic                           i_last_entry,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [fsha_pkg::TALLY_W-1:0]   o_slots_used,
    output logic [fsha_pkg::TALLY_W-1:0]   o_files,
    output logic [fsha_pkg::DATA_W-1:0]    o_used_bytes,
    output logic [fsha_pkg::DATA_W-1:0]    o_reserved_bytes,
    output logic [fsha_pkg::DATA_W-1:0]    o_free_bytes,
    output logic [fsha_pkg::DATA_W-1:0]    o_largest_hole,
    output logic [fsha_pkg::DATA_W-1:0]    o_region_bytes,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fsha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fsha_pkg::DATA_W-1:0]    i_cfg_data
);
    import fsha_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Configuration writes land at once
    assign o_cfg_ready = 1'b1;

    fsha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_entry (i_last_entry),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    fsha_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_entry_state    (i_entry_state),
        .i_entry_offset   (i_entry_offset),
        .i_entry_capacity (i_entry_capacity),
        .i_entry_size     (i_entry_size),
        .o_slots_used     (o_slots_used),
        .o_files          (o_files),
        .o_used_bytes     (o_used_bytes),
        .o_reserved_bytes (o_reserved_bytes),
        .o_free_bytes     (o_free_bytes),
        .o_largest_hole   (o_largest_hole),
        .o_region_bytes   (o_region_bytes)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the free space hole analyzer: directed and random passes.
module tb;
    import fsha_pkg::*;

    localparam logic [STATE_W-1:0] ST_DELETED = 2'd3;

    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 2 * MAX_SLOTS + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ENTRIES  = 90;
    localparam int FULL_PASS_LEN  = 150;

    // One directory entry as offered on the request channel
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [DATA_W-1:0]  offset;
        logic [DATA_W-1:0]  capacity;
        logic [DATA_W-1:0]  size;
        logic               last;
    } t_entry;

    // Totals reported at the end of a directory pass
    typedef struct packed {
        logic [TALLY_W-1:0] slots;
        logic [TALLY_W-1:0] files;
        logic [DATA_W-1:0]  used;
        logic [DATA_W-1:0]  reserved;
        logic [DATA_W-1:0]  free_total;
        logic [DATA_W-1:0]  hole;
        logic [DATA_W-1:0]  region;
    } t_summary;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [STATE_W-1:0]   i_entry_state;
    logic [DATA_W-1:0]    i_entry_offset;
    logic [DATA_W-1:0]    i_entry_capacity;
    logic [DATA_W-1:0]    i_entry_size;
    logic                 i_last_entry;
    logic                 o_valid;
    logic                 i_stall;
    logic [TALLY_W-1:0]   o_slots_used;
    logic [TALLY_W-1:0]   o_files;
    logic [DATA_W-1:0]    o_used_bytes;
    logic [DATA_W-1:0]    o_reserved_bytes;
    logic [DATA_W-1:0]    o_free_bytes;
    logic [DATA_W-1:0]    o_largest_hole;
    logic [DATA_W-1:0]    o_region_bytes;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    free_space_hole_analyzer_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_entry_state    (i_entry_state),
        .i_entry_offset   (i_entry_offset),
        .i_entry_capacity (i_entry_capacity),
        .i_entry_size     (i_entry_size),
        .i_last_entry     (i_last_entry),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_slots_used     (o_slots_used),
        .o_files          (o_files),
        .o_used_bytes     (o_used_bytes),
        .o_reserved_bytes (o_reserved_bytes),
        .o_free_bytes     (o_free_bytes),
        .o_largest_hole   (o_largest_hole),
        .o_region_bytes   (o_region_bytes),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Pass totals still owed by the block, oldest first
    t_summary summary_q[$];
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    bit       no_idle      = 1'b0;
    int       hold_seq     = 0;

    // Shadow of the block: sorted occupied ranges, tallies and region bounds
    logic [DATA_W-1:0]  occ_off [MAX_SLOTS];
    logic [DATA_W-1:0]  occ_end [MAX_SLOTS];
    int                 occ_count      = 0;
    logic [TALLY_W-1:0] slot_tally     = '0;
    logic [TALLY_W-1:0] file_tally     = '0;
    logic [DATA_W-1:0]  used_total     = '0;
    logic [DATA_W-1:0]  reserved_total = '0;
    logic [DATA_W-1:0]  cfg_data_start = '0;
    logic [DATA_W-1:0]  cfg_region_end = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a 32-bit sum at all ones
    function automatic logic [DATA_W-1:0] clamp_add(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        return (a > ~b) ? {DATA_W{1'b1}} : a + b;
    endfunction

    function automatic string summary_str(input t_summary s);
        return $sformatf("slots=%0d files=%0d used=%h reserved=%h free=%h hole=%h region=%h",
                         s.slots, s.files, s.used, s.reserved, s.free_total, s.hole,
                         s.region);
    endfunction

    // Account one accepted request; on the last entry scan for gaps and queue the totals
    task automatic tally_entry(input t_entry e);
        int                j;
        logic [DATA_W-1:0] cursor;
        logic [DATA_W-1:0] gap;
        t_summary          s;
        if (e.state != ST_FREE) begin
            if (slot_tally != TALLY_MAX) slot_tally++;
            if (e.state == ST_VALID) begin
                if (file_tally != TALLY_MAX) file_tally++;
                used_total     = clamp_add(used_total, e.size);
                reserved_total = clamp_add(reserved_total, e.capacity);
            end
            // insert behind any equal offset, drop when the store is full
            if ((e.state == ST_VALID || e.state == ST_WRITING) && occ_count < MAX_SLOTS) begin
                j = occ_count;
                while (j > 0 && occ_off[j-1] > e.offset) begin
                    occ_off[j] = occ_off[j-1];
                    occ_end[j] = occ_end[j-1];
                    j--;
                end
                occ_off[j] = e.offset;
                occ_end[j] = e.offset + e.capacity;
                occ_count++;
            end
        end
        if (e.last) begin
            cursor       = cfg_data_start;
            s.free_total = '0;
            s.hole       = '0;
            for (j = 0; j < occ_count; j++) begin
                if (occ_off[j] > cursor) begin
                    gap          = occ_off[j] - cursor;
                    s.free_total = clamp_add(s.free_total, gap);
                    if (gap > s.hole) s.hole = gap;
                end
                if (occ_end[j] > cursor) cursor = occ_end[j];
            end
            if (cursor < cfg_region_end) begin
                gap          = cfg_region_end - cursor;
                s.free_total = clamp_add(s.free_total, gap);
                if (gap > s.hole) s.hole = gap;
            end
            s.slots    = slot_tally;
            s.files    = file_tally;
            s.used     = used_total;
            s.reserved = reserved_total;
            s.region   = cfg_region_end - cfg_data_start;
            summary_q.push_back(s);
            occ_count      = 0;
            slot_tally     = '0;
            file_tally     = '0;
            used_total     = '0;
            reserved_total = '0;
        end
    endtask

    // Offer one request, idling at random first; valid stays high for a following request
    task automatic send_entry(input t_entry e);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid          <= 1'b1;
        i_entry_state    <= e.state;
        i_entry_offset   <= e.offset;
        i_entry_capacity <= e.capacity;
        i_entry_size     <= e.size;
        i_last_entry     <= e.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tally_entry(e);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both region bounds back to back; only called while the block is idle
    task automatic set_region(input logic [DATA_W-1:0] start, input logic [DATA_W-1:0] stop);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DATA_START;
        i_cfg_data  <= start;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_data_start = start;
        i_cfg_index <= CFG_REGION_END;
        i_cfg_data  <= stop;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_region_end = stop;
        i_cfg_valid <= 1'b0;
    endtask

    // Random entry; shaped ones land in a window above data_start with modest capacities
    function automatic t_entry random_entry(input bit shaped);
        t_entry            e;
        logic [DATA_W-1:0] window;
        window  = (cfg_region_end > cfg_data_start) ? cfg_region_end - cfg_data_start
                                                    : 32'h0001_0000;
        e.state = STATE_W'($urandom_range(3));
        if (shaped) begin
            e.offset   = cfg_data_start + $urandom % window;
            e.capacity = $urandom % (window / 8 + 1);
        end else begin
            e.offset   = $urandom;
            e.capacity = $urandom;
        end
        e.size = ($urandom_range(1) != 0) ? $urandom : $urandom % 32'h0010_0000;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic send_pass(input int len, input bit shaped);
        t_entry e;
        for (int i = 0; i < len; i++) begin
            e      = random_entry(shaped);
            e.last = (i == len - 1);
            send_entry(e);
        end
    endtask

    // Mostly short shaped passes, some long ones and some raw noise
    task automatic run_random_phase(input logic [DATA_W-1:0] start,
                                    input logic [DATA_W-1:0] stop, input bit quiet);
        int sent;
        int len;
        set_region(start, stop);
        no_idle = quiet;
        sent    = 0;
        while (sent < PHASE_ENTRIES) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_pass(len, $urandom_range(99) < 80);
            sent += len;
        end
        settle();
        no_idle = 1'b0;
    endtask

    task automatic test_empty_region();
        set_region(32'h0, 32'h0);
        send_entry('{ST_FREE, 32'h0, 32'h0, 32'h0, 1'b1});
        settle();
    endtask

    // Every state code, a range below data_start, equal offsets, zero capacity
    task automatic test_state_codes();
        set_region(32'h0000_1000, 32'h0001_0000);
        send_entry('{ST_FREE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        send_entry('{ST_WRITING, 32'h0000_3000, 32'h0000_1000, 32'h0000_0055, 1'b0});
        send_entry('{ST_VALID,   32'h0000_2000, 32'h0000_0800, 32'h0000_0700, 1'b0});
        send_entry('{ST_DELETED, 32'h0000_1800, 32'h0000_0100, 32'h0000_0010, 1'b0});
        send_entry('{ST_WRITING, 32'h0000_0000, 32'h0000_1100, 32'h0000_0000, 1'b0});
        send_entry('{ST_VALID,   32'h0000_2000, 32'h0000_0100, 32'h0000_0000, 1'b1});
        send_entry('{ST_VALID,   32'h0000_8000, 32'h0000_0000, 32'h0000_0001, 1'b1});
        settle();
    endtask

    // Size and capacity sums clamp at all ones
    task automatic test_saturating_sums();
        set_region(32'h0, 32'hFFFF_FFFF);
        send_entry('{ST_VALID, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        send_entry('{ST_VALID, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1});
        settle();
    endtask

    // Wrapped range ends leave the cursor low, so the gap sum clamps
    task automatic test_wrapped_ranges();
        set_region(32'h0, 32'hFFFF_FFFF);
        send_entry('{ST_WRITING, 32'h8000_0000, 32'h8000_0010, 32'h0000_0000, 1'b0});
        send_entry('{ST_WRITING, 32'hF000_0000, 32'h2000_0000, 32'h0000_0000, 1'b0});
        send_entry('{ST_VALID,   32'hF000_0000, 32'h0000_0100, 32'h0000_0020, 1'b0});
        send_entry('{ST_FREE,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1});
        settle();
    endtask

    // Region end below or equal to data_start: no tail gap; region size wraps when end is below
    task automatic test_inverted_region();
        set_region(32'hFFFF_FFFF, 32'h0);
        send_entry('{ST_VALID, 32'h0000_0010, 32'h0000_0010, 32'h0000_0010, 1'b1});
        settle();
        set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_entry('{ST_WRITING, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1});
        settle();
    endtask

    task automatic test_random_passes();
        logic [DATA_W-1:0] base;
        run_random_phase(32'h0000_1000, 32'h0004_1000, 1'b0);
        run_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        run_random_phase(32'h0002_0000, 32'h0001_0000, 1'b1);
        run_random_phase($urandom, $urandom, 1'b0);
        base = $urandom;
        run_random_phase(base, base + $urandom_range(32'h100, 32'h10_0000), 1'b0);
    endtask

    // Descending offsets force the longest shifts; the pass overflows store and tallies
    task automatic test_full_store();
        t_entry e;
        set_region(32'h0, 32'h0010_0000);
        for (int i = 0; i < FULL_PASS_LEN; i++) begin
            e = random_entry(1'b1);
            if (i < MAX_SLOTS) begin
                e.offset   = 32'h0008_0000 - DATA_W'(i) * 32'h400;
                e.capacity = 32'h300;
            end
            e.state = (i % 13 == 12) ? ST_WRITING : ST_VALID;
            e.last  = (i == FULL_PASS_LEN - 1);
            send_entry(e);
        end
        settle();
    endtask

    // Receiver holds off while short passes keep coming, so the block backs up
    task automatic test_backpressure();
        set_region(32'h0000_4000, 32'h0004_0000);
        no_idle = 1'b1;
        hold_seq++;
        for (int p = 0; p < 6; p++) send_pass(3, 1'b1);
        settle();
        no_idle = 1'b0;
    endtask

    // Drive the result stall: random idling, or a long counted hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest owed totals
    always @(posedge i_clk) begin : result_check
        t_summary got;
        t_summary want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_slots_used, o_files, o_used_bytes, o_reserved_bytes, o_free_bytes,
                    o_largest_hole, o_region_bytes};
            if (summary_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: %s", summary_str(got));
            end else begin
                want = summary_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 summary_str(want), summary_str(got));
                end
            end
        end
    end

    // Watchdog: end the run when no handshake completes for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_valid          <= 1'b0;
        i_entry_state    <= ST_FREE;
        i_entry_offset   <= '0;
        i_entry_capacity <= '0;
        i_entry_size     <= '0;
        i_last_entry     <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_DATA_START;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_region();
        test_state_codes();
        test_saturating_sums();
        test_wrapped_ranges();
        test_inverted_region();
        test_random_passes();
        test_full_store();
        test_backpressure();

        if (summary_q.size() != 0)
            $display("%0d results never arrived", summary_q.size());
        if (mismatches == 0 && summary_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
